@@ rtl/packbits_rle_encoder_defines.svh @@
// Assertion macros for the PackBits encoder.
// Used by the top level only; no other dependencies.
`ifndef PACKBITS_RLE_ENCODER_DEFINES_SVH
`define PACKBITS_RLE_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PBE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define PBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pbe_pkg.sv @@
// Shared types, constants and header helpers for the PackBits encoder.
// No dependencies.
package pbe_pkg;

   localparam int          STORE_DEPTH  = 32;
   localparam int          IDX_W        = $clog2(STORE_DEPTH);
   localparam int          LEN_W        = $clog2(STORE_DEPTH + 1);
   localparam logic [7:0]  END_MARKER   = 8'd128;
   localparam logic [8:0]  RUN_HDR_BASE = 9'd257;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_HDR,
      SEQ_DATA,
      SEQ_MARK
   } seq_state_type;

   // One flush: a header and len data bytes; byte0 is the first data byte
   typedef struct packed {
      logic             valid;
      logic [7:0]       hdr;
      logic [7:0]       byte0;
      logic [LEN_W-1:0] len;
   } job_type;

   typedef struct packed {
      job_type job1;
      job_type job2;
      logic    mark;
   } plan_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } wr_type;

   function automatic job_type run_job(input logic [7:0] n, input logic [7:0] b);
      job_type j;
      j.valid = 1'b1;
      j.hdr   = 8'(RUN_HDR_BASE - {1'b0, n});
      j.byte0 = b;
      j.len   = LEN_W'(1);
      return j;
   endfunction

   function automatic job_type lit_job(input logic [7:0] n, input logic [7:0] first);
      job_type j;
      j.valid = 1'b1;
      j.hdr   = n - 8'd1;
      j.byte0 = first;
      j.len   = n[LEN_W-1:0];
      return j;
   endfunction

endpackage

@@ rtl/pbe_if.sv @@
// Valid/ready channel interfaces for the PackBits encoder.
// No dependencies.
interface pbe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_plane;

   modport source (output valid, output data_byte, output end_of_plane, input ready);
   modport sink   (input valid, input data_byte, input end_of_plane, output ready);
endinterface

interface pbe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/packbits_rle_encoder.sv @@
// PackBits run-length encoder, top level.
// Depends on pbe_pkg, pbe_if, pbe_group, pbe_emit and packbits_rle_encoder_defines.svh.
//
// req_ch carries one raw byte per transfer with end_of_plane on the final byte of
// a plane. rsp_ch carries the encoded stream one byte per transfer: run headers
// (257-n), literal headers (n-1), data bytes and the end marker 128. out_last is
// set on the final byte caused by one input transfer.
// An input byte that only extends a group is taken and produces nothing. A byte
// that closes a group is followed by its encoded bytes (header plus data bytes,
// up to 33 for a full literal), and end_of_plane adds the final flush and the
// marker; the emit sequencer writes one byte per cycle into the output register
// while the receiver does not stall it. req_ch.ready is high whenever the
// sequencer is idle, even while the last result still sits in the output register.
// A stalled receiver holds the output register and the sequencer in place;
// nothing is dropped. Synchronous reset returns to run mode with no group
// pending; the literal store is not cleared, since only written entries are read.
module packbits_rle_encoder #(
   parameter int LITERAL_MAX = 32,
   parameter int RUN_MAX     = 128
) (
   input logic      clock,
   input logic      reset,
   pbe_req_if.sink  req_ch,
   pbe_rsp_if.source rsp_ch
);
   import pbe_pkg::*;
   `include "packbits_rle_encoder_defines.svh"

   plan_type plan;
   wr_type   wr;
   logic     busy;
   logic     accept;
   logic     eop_accept;
   logic     mid_byte;

   assign req_ch.ready = !busy;
   assign accept       = req_ch.valid && !busy;
   assign eop_accept   = accept && req_ch.end_of_plane;
   assign mid_byte     = rsp_ch.valid && !rsp_ch.out_last;

   pbe_group #(
      .LITERAL_MAX (LITERAL_MAX),
      .RUN_MAX     (RUN_MAX)
   ) u_group (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_ch.data_byte),
      .end_of_plane (req_ch.end_of_plane),
      .plan         (plan),
      .wr           (wr)
   );

   pbe_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .plan         (plan),
      .wr           (wr),
      .busy         (busy),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .rsp_out_byte (rsp_ch.out_byte),
      .rsp_out_last (rsp_ch.out_last)
   );

   // every end of plane emits at least the marker
   `PBE_ASSERT_NEXT(a_eop_busy, clock, reset, eop_accept, busy, "end of plane left no output")
   // a byte that is not the last of its input means more bytes are queued
   `PBE_ASSERT_NOW(a_more_pending, clock, reset, mid_byte, busy, "sequencer idle mid-response")

endmodule

@@ rtl/pbe_group.sv @@
// Group tracker: run/literal state and the flush plan for each input byte.
// Depends on pbe_pkg.
module pbe_group #(
   parameter int LITERAL_MAX = 32,
   parameter int RUN_MAX     = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_plane,
   output pbe_pkg::plan_type plan,
   output pbe_pkg::wr_type   wr
);
   import pbe_pkg::*;

   localparam logic [7:0] LitMax = 8'(LITERAL_MAX);
   localparam logic [7:0] RunMax = 8'(RUN_MAX);

   logic [7:0] gc_ff, gc_in;
   logic [7:0] rv_ff, rv_in;
   logic [7:0] first_ff, first_in;
   logic       lit_ff, lit_in;

   always_comb begin
      gc_in    = gc_ff;
      rv_in    = rv_ff;
      first_in = first_ff;
      lit_in   = lit_ff;
      plan     = '0;
      wr       = '0;

      if (gc_ff == 8'd0) begin
         rv_in  = data_byte;
         gc_in  = 8'd1;
         lit_in = 1'b0;
      end else if (!lit_ff) begin
         if (data_byte == rv_ff) begin
            if (gc_ff >= RunMax) begin
               plan.job1 = run_job(gc_ff, rv_ff);
               gc_in     = 8'd1;
            end else begin
               gc_in = gc_ff + 8'd1;
            end
         end else if (gc_ff == 8'd1) begin
            // lone differing byte: open a literal of two
            first_in = rv_ff;
            wr.en    = accept;
            wr.addr  = IDX_W'(1);
            wr.data  = data_byte;
            gc_in    = 8'd2;
            lit_in   = 1'b1;
            rv_in    = data_byte;
         end else begin
            plan.job1 = run_job(gc_ff, rv_ff);
            rv_in     = data_byte;
            gc_in     = 8'd1;
         end
      end else begin
         if (data_byte == rv_ff) begin
            // repeat: drop the last literal byte into a run of two
            plan.job1 = lit_job(gc_ff - 8'd1, first_ff);
            gc_in     = 8'd2;
            lit_in    = 1'b0;
         end else if (gc_ff >= LitMax) begin
            plan.job1 = lit_job(gc_ff, first_ff);
            gc_in     = 8'd1;
            lit_in    = 1'b0;
            rv_in     = data_byte;
         end else begin
            wr.en   = accept;
            wr.addr = gc_ff[IDX_W-1:0];
            wr.data = data_byte;
            gc_in   = gc_ff + 8'd1;
            rv_in   = data_byte;
         end
      end

      if (end_of_plane) begin
         plan.job2 = lit_in ? lit_job(gc_in, first_in) : run_job(gc_in, rv_in);
         plan.mark = 1'b1;
         gc_in     = 8'd0;
         lit_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gc_ff  <= 8'd0;
         rv_ff  <= 8'd0;
         lit_ff <= 1'b0;
      end else if (accept) begin
         gc_ff  <= gc_in;
         rv_ff  <= rv_in;
         lit_ff <= lit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= first_in;
      end
   end

endmodule

@@ rtl/pbe_emit.sv @@
// Emit sequencer: literal store, byte counter and output register.
// Depends on pbe_pkg.
module pbe_emit (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  pbe_pkg::plan_type plan,
   input  pbe_pkg::wr_type   wr,
   output logic              busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last
);
   import pbe_pkg::*;

   seq_state_type    state_ff, state_in;
   plan_type         plan_ff;
   logic             cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       mem [STORE_DEPTH];
   logic [7:0]       rd_data_ff;
   logic             ov_ff, ov_in;
   logic [7:0]       ob_ff;
   logic             ol_ff;

   job_type    cur_job;
   logic       slot_free;
   logic       data_done;
   logic       emit_fire;
   logic [7:0] emit_byte;

   assign cur_job   = cur_ff ? plan_ff.job2 : plan_ff.job1;
   assign slot_free = !ov_ff || rsp_ready;
   assign data_done = ({1'b0, idx_ff} == (cur_job.len - LEN_W'(1)));
   assign busy      = (state_ff != SEQ_IDLE);

   // next state
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            idx_in = '0;
            cur_in = 1'b0;
            if (accept) begin
               if (plan.job1.valid) begin
                  state_in = SEQ_HDR;
               end else if (plan.job2.valid) begin
                  state_in = SEQ_HDR;
                  cur_in   = 1'b1;
               end else if (plan.mark) begin
                  state_in = SEQ_MARK;
               end
            end
         end
         SEQ_HDR: begin
            if (slot_free) begin
               state_in = SEQ_DATA;
               idx_in   = '0;
            end
         end
         SEQ_DATA: begin
            if (slot_free) begin
               if (!data_done) begin
                  idx_in = idx_ff + IDX_W'(1);
               end else if (!cur_ff && plan_ff.job2.valid) begin
                  state_in = SEQ_HDR;
                  cur_in   = 1'b1;
                  idx_in   = '0;
               end else if (plan_ff.mark) begin
                  state_in = SEQ_MARK;
               end else begin
                  state_in = SEQ_IDLE;
               end
            end
         end
         SEQ_MARK: begin
            if (slot_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      emit_fire = 1'b0;
      emit_byte = END_MARKER;
      unique case (state_ff)
         SEQ_IDLE: begin
            emit_fire = 1'b0;
         end
         SEQ_HDR: begin
            emit_fire = slot_free;
            emit_byte = cur_job.hdr;
         end
         SEQ_DATA: begin
            emit_fire = slot_free;
            emit_byte = (idx_ff == '0) ? cur_job.byte0 : rd_data_ff;
         end
         SEQ_MARK: begin
            emit_fire = slot_free;
            emit_byte = END_MARKER;
         end
         default: emit_fire = 1'b0;
      endcase
   end

   assign ov_in = emit_fire || (ov_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         cur_ff   <= 1'b0;
         idx_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         idx_ff   <= idx_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         plan_ff <= plan;
      end
      if (emit_fire) begin
         ob_ff <= emit_byte;
         ol_ff <= (state_in == SEQ_IDLE);
      end
   end

   // literal store: one write port, one registered read that tracks the next index
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[idx_in];
   end

   assign rsp_valid    = ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_out_last = ol_ff;

endmodule
